[src/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    // Default widths of the byte counter and the phase timer.
    localparam int COUNT_WIDTH_DEF = 8;
    localparam int TIMER_WIDTH_DEF = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_HOLD  = 2'd0;
    localparam logic [1:0] REG_HALF_BIT    = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] START_HOLD_RST  = 8'd4;
    localparam logic [7:0] HALF_BIT_RST    = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // Command codes carried by each tick.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Everything the engine reports for one tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_enable;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       busy_res;
        logic       xfer_done;
        logic       ack_error;
    } i2cm_result_t;

endpackage

[src/i2cm_core.sv]
// Bus sequencer of the I2C master: configuration, transaction state and per-tick outputs.
`timescale 1ns / 1ps

module i2cm_core import i2cm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    input  logic         step_en,
    input  logic [1:0]   func,
    input  logic [6:0]   dev_addr,
    input  logic [7:0]   reg_byte,
    input  logic [7:0]   read_count,
    input  logic         sda_in,
    output i2cm_result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_TXL, PH_TXH, PH_AL, PH_AH,
        PH_RXL, PH_RXH, PH_ML, PH_MH, PH_P1, PH_P2
    } phase_t;

    // Compare width for durations against the timer range.
    localparam int DW  = ((TIMER_WIDTH > 8) ? TIMER_WIDTH : 8) + 1;
    localparam int CW2 = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [DW-1:0] TMAX = DW'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // A zero duration acts as one; long durations saturate at the timer range.
    function automatic logic [DW-1:0] clamp_dur(input logic [7:0] d);
        logic [DW-1:0] w;
        w = DW'(d);
        if (w == '0) begin
            return DW'(1);
        end else if (w > TMAX) begin
            return TMAX;
        end
        return w;
    endfunction

    logic [7:0] start_hold_reg, half_bit_reg, ack_timeout_reg;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             shift_reg, shift_next;
    logic [3:0]             bit_index_reg, bit_index_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [COUNT_WIDTH-1:0] bytes_left_reg, bytes_left_next;
    logic [TIMER_WIDTH-1:0] ack_wait_reg, ack_wait_next;
    logic                   read_mode_reg, read_mode_next;
    logic [7:0]             pending_reg, pending_next;
    logic                   error_reg, error_next;

    // Values in effect for this tick, after a command in idle is loaded.
    phase_t                 ph_c;
    logic [7:0]             sh_c;
    logic [3:0]             bi_c;
    logic [TIMER_WIDTH-1:0] tm_c;
    logic [COUNT_WIDTH-1:0] bl_c;
    logic [TIMER_WIDTH-1:0] aw_c;
    logic                   rm_c;
    logic                   err_c;
    logic                   start;
    logic [CW2-1:0]         rc_w;
    logic [7:0]             dur_sel;
    logic [DW-1:0]          timer_inc;
    logic                   tick_hit;
    logic [TIMER_WIDTH-1:0] timer_adv;
    logic [3:0]             bi_inc;
    logic [TIMER_WIDTH-1:0] aw_inc;
    logic [COUNT_WIDTH-1:0] bl_dec;
    logic [7:0]             sh_rx;

    // Load a new transaction and pick the active phase.
    always_comb begin
        start = (phase_reg == PH_IDLE) && ((func == FUNC_WRITE) || (func == FUNC_READ));
        rc_w  = CW2'(read_count);
        ph_c  = phase_reg;
        sh_c  = shift_reg;
        bi_c  = bit_index_reg;
        tm_c  = timer_reg;
        bl_c  = bytes_left_reg;
        aw_c  = ack_wait_reg;
        rm_c  = read_mode_reg;
        pending_next = pending_reg;
        err_c = error_reg;
        if (start) begin
            rm_c = (func == FUNC_READ);
            sh_c = {dev_addr, rm_c};
            pending_next = reg_byte;
            if (rm_c) begin
                bl_c = (rc_w > CW2'(CMAX)) ? CMAX : COUNT_WIDTH'(rc_w);
            end else begin
                bl_c = COUNT_WIDTH'(1);
            end
            bi_c  = '0;
            tm_c  = '0;
            aw_c  = '0;
            err_c = 1'b0;
            ph_c  = PH_S1;
        end
    end

    // Phase timer: one shared counter against the duration of the active phase.
    always_comb begin
        if (ph_c == PH_S1 || ph_c == PH_S2 || ph_c == PH_P1 || ph_c == PH_P2) begin
            dur_sel = start_hold_reg;
        end else begin
            dur_sel = half_bit_reg;
        end
        timer_inc = DW'(tm_c) + DW'(1);
        tick_hit  = (timer_inc >= clamp_dur(dur_sel));
        timer_adv = tick_hit ? '0 : TIMER_WIDTH'(timer_inc);
        bi_inc    = bi_c + 4'd1;
        aw_inc    = aw_c + TIMER_WIDTH'(1);
        bl_dec    = bl_c - COUNT_WIDTH'(1);
        sh_rx     = {sh_c[6:0], sda_in};
    end

    // Phase sequencing and the bus levels for this tick.
    always_comb begin
        phase_next      = ph_c;
        shift_next      = sh_c;
        bit_index_next  = bi_c;
        timer_next      = tm_c;
        bytes_left_next = bl_c;
        ack_wait_next   = aw_c;
        read_mode_next  = rm_c;
        error_next      = err_c;
        result            = '0;
        result.scl_out    = 1'b1;
        result.sda_out    = 1'b1;
        result.sda_enable = 1'b1;
        result.busy_res   = (ph_c != PH_IDLE);

        unique case (ph_c)
            PH_IDLE: begin
            end
            PH_S1: begin
                timer_next = timer_adv;
                if (tick_hit) begin
                    phase_next = PH_S2;
                end
            end
            PH_S2: begin
                result.sda_out = 1'b0;
                timer_next = timer_adv;
                if (tick_hit) begin
                    phase_next = PH_TXL;
                end
            end
            PH_TXL, PH_TXH: begin
                result.scl_out = (ph_c == PH_TXH);
                result.sda_out = sh_c[7];
                timer_next = timer_adv;
                if (tick_hit) begin
                    if (ph_c == PH_TXL) begin
                        phase_next = PH_TXH;
                    end else begin
                        shift_next = {sh_c[6:0], 1'b0};
                        if (bi_inc >= 4'd8) begin
                            bit_index_next = '0;
                            phase_next = PH_AL;
                        end else begin
                            bit_index_next = bi_inc;
                            phase_next = PH_TXL;
                        end
                    end
                end
            end
            PH_AL: begin
                result.scl_out    = 1'b0;
                result.sda_enable = 1'b0;
                timer_next = timer_adv;
                if (tick_hit) begin
                    ack_wait_next = '0;
                    phase_next = PH_AH;
                end
            end
            PH_AH: begin
                result.sda_enable = 1'b0;
                if (!sda_in) begin
                    timer_next = '0;
                    if (!rm_c && bl_c != '0) begin
                        bytes_left_next = '0;
                        shift_next = pending_next;
                        phase_next = PH_TXL;
                    end else if (rm_c && bl_c != '0) begin
                        shift_next = '0;
                        phase_next = PH_RXL;
                    end else begin
                        phase_next = PH_P1;
                    end
                end else begin
                    ack_wait_next = aw_inc;
                    if (DW'(aw_inc) >= clamp_dur(ack_timeout_reg)) begin
                        error_next = 1'b1;
                        timer_next = '0;
                        phase_next = PH_P1;
                    end
                end
            end
            PH_RXL: begin
                result.scl_out    = 1'b0;
                result.sda_enable = 1'b0;
                timer_next = timer_adv;
                if (tick_hit) begin
                    phase_next = PH_RXH;
                end
            end
            PH_RXH: begin
                result.sda_enable = 1'b0;
                timer_next = timer_adv;
                if (tick_hit) begin
                    shift_next = sh_rx;
                    if (bi_inc >= 4'd8) begin
                        bit_index_next  = '0;
                        bytes_left_next = bl_dec;
                        result.rx_valid = 1'b1;
                        result.rx_byte  = sh_rx;
                        result.rx_last  = (bl_dec == '0);
                        phase_next = PH_ML;
                    end else begin
                        bit_index_next = bi_inc;
                        phase_next = PH_RXL;
                    end
                end
            end
            PH_ML, PH_MH: begin
                // The last byte gets a NACK, the others an ACK.
                result.scl_out = (ph_c == PH_MH);
                result.sda_out = (bl_c == '0);
                timer_next = timer_adv;
                if (tick_hit) begin
                    if (ph_c == PH_ML) begin
                        phase_next = PH_MH;
                    end else if (bl_c != '0) begin
                        shift_next = '0;
                        phase_next = PH_RXL;
                    end else begin
                        phase_next = PH_P1;
                    end
                end
            end
            PH_P1: begin
                result.scl_out = 1'b0;
                result.sda_out = 1'b0;
                timer_next = timer_adv;
                if (tick_hit) begin
                    phase_next = PH_P2;
                end
            end
            PH_P2: begin
                result.sda_out = 1'b0;
                timer_next = timer_adv;
                if (tick_hit) begin
                    result.sda_out   = 1'b1;
                    result.xfer_done = 1'b1;
                    result.ack_error = err_c;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                timer_next = '0;
                result.busy_res = 1'b0;
            end
        endcase

        // A released line reads as high.
        if (!result.sda_enable) begin
            result.sda_out = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_hold_reg  <= START_HOLD_RST;
            half_bit_reg    <= HALF_BIT_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_HOLD:  start_hold_reg  <= cfg_wdata;
                REG_HALF_BIT:    half_bit_reg    <= cfg_wdata;
                REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Transaction state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            shift_reg      <= '0;
            bit_index_reg  <= '0;
            timer_reg      <= '0;
            bytes_left_reg <= '0;
            ack_wait_reg   <= '0;
            read_mode_reg  <= 1'b0;
            pending_reg    <= '0;
            error_reg      <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            bit_index_reg  <= bit_index_next;
            timer_reg      <= timer_next;
            bytes_left_reg <= bytes_left_next;
            ack_wait_reg   <= ack_wait_next;
            read_mode_reg  <= read_mode_next;
            pending_reg    <= pending_next;
            error_reg      <= error_next;
        end
    end

endmodule

[src/i2c_master_bit_engine.sv]
// Top level of the tick-driven I2C master bit engine with its output register.
//
// Usage: every input beat on the s_ channel is one bus time tick. It carries a
// command (tick only, start write, start read) with its address, register byte
// and read count, plus the sampled SDA level. Each input beat yields exactly one
// output beat on the m_ channel with the SCL/SDA levels to drive for that tick,
// any received byte, and busy, done and ACK error flags.
// The result of a tick appears on the m_ channel in the cycle after its input
// beat is accepted. Throughput: one tick per cycle while the receiver keeps up;
// the transaction state and the output register both update in the accepting
// cycle, and a single register stage decouples the two channels.
// When the receiver stalls, the held result stays on m_ and s_ready drops until
// the result is taken; no tick is dropped or repeated.
// Reset (aresetn low, synchronous) returns the engine to idle, loads the default
// timing registers and empties the output register. Timing registers are written
// through cfg_wr_en/cfg_index/cfg_wdata, by the user while idle; not enforced.
`timescale 1ns / 1ps

module i2c_master_bit_engine import i2cm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [6:0] s_dev_addr,
    input  logic [7:0] s_reg_byte,
    input  logic [7:0] s_read_count,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_out,
    output logic       m_sda_out,
    output logic       m_sda_enable,
    output logic [7:0] m_rx_byte,
    output logic       m_rx_valid,
    output logic       m_rx_last,
    output logic       m_busy_res,
    output logic       m_xfer_done,
    output logic       m_ack_error
);

    logic         accept;
    logic         m_valid_reg;
    i2cm_result_t result;
    i2cm_result_t out_reg;

    // A new beat is taken whenever the output register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    i2cm_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .step_en    (accept),
        .func       (s_func),
        .dev_addr   (s_dev_addr),
        .reg_byte   (s_reg_byte),
        .read_count (s_read_count),
        .sda_in     (s_sda_in),
        .result     (result)
    );

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_scl_out    = out_reg.scl_out;
    assign m_sda_out    = out_reg.sda_out;
    assign m_sda_enable = out_reg.sda_enable;
    assign m_rx_byte    = out_reg.rx_byte;
    assign m_rx_valid   = out_reg.rx_valid;
    assign m_rx_last    = out_reg.rx_last;
    assign m_busy_res   = out_reg.busy_res;
    assign m_xfer_done  = out_reg.xfer_done;
    assign m_ack_error  = out_reg.ack_error;

endmodule
